[rtl/fdl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdl_pkg
// shared types and constants of the interpolating feedback delay
// ----------------------------------------------------------------------------
package fdl_pkg;

    localparam int DELAY_BITS    = 17;
    localparam int FRAC_BITS     = 16;
    localparam int GAIN_BITS     = 16;
    localparam int COEF_BITS     = 18;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;
    localparam int RED_CNT_BITS  = $clog2(DELAY_BITS);

    localparam logic [GAIN_BITS:0] GAIN_ONE = 17'd32768;
    localparam logic [FRAC_BITS:0] FRAC_ONE = 17'd65536;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DELAY_WHOLE    = 2'd0,
        REG_DELAY_FRACTION = 2'd1,
        REG_FEEDBACK_GAIN  = 2'd2,
        REG_WET_GAIN       = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_RD0,
        ST_RD1,
        ST_BLEND0,
        ST_BLEND1,
        ST_DLY,
        ST_FB,
        ST_WET,
        ST_DRY,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic accum;
    } mac_ctrl_t;

endpackage
`default_nettype wire

[rtl/fdl_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdl_mac
// shared multiply-accumulate unit: registered product, then accumulator
// ----------------------------------------------------------------------------
module fdl_mac
    import fdl_pkg::*;
#(
    parameter int A_BITS = 24
)
(
    input  wire logic                             clk,
    input  wire mac_ctrl_t                        ctrl,
    input  wire logic signed [A_BITS-1:0]         op_a,
    input  wire logic signed [COEF_BITS-1:0]      op_b,
    output logic signed [A_BITS+COEF_BITS:0]      acc
);

    localparam int P_BITS = A_BITS + COEF_BITS;

    logic signed [P_BITS-1:0] prod_reg;
    logic signed [P_BITS:0]   acc_reg;
    logic signed [P_BITS:0]   acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.load)
        begin
            acc_next = (P_BITS+1)'(prod_reg);
        end
        else if (ctrl.accum)
        begin
            acc_next = acc_reg + (P_BITS+1)'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

[rtl/fdl_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdl_ram
// single-port sample memory with registered read data
// ----------------------------------------------------------------------------
module fdl_ram
#(
    parameter int DEPTH = 262144,
    parameter int WIDTH = 24
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/feedback_delay_line_interp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// feedback_delay_line_interp
// multi-channel feedback delay with a linearly interpolated fractional tap
// ----------------------------------------------------------------------------
// usage:
//   s_* takes one word per item: s_tdata holds the sample, s_tuser the channel.
//   m_* returns one word per item: m_tdata the mixed sample, m_tuser the channel.
//   cfg_we / cfg_index / cfg_data write the delay, fraction and gain registers;
//   write them only while no item is in flight.
// timing:
//   s_tready stays low from an accepted word until its result is loaded into the
//   output register, so a word is taken only once the one before is through. the
//   sequence is set by the single shared multiplier (five products) and the
//   single memory port (two tap reads, one write). the first item after reset or
//   after a delay_whole write first passes a reduce step that takes the delay
//   modulo the line depth by a reciprocal multiply.
// reset:
//   registers, write positions and fill counts clear; a per-channel fill count
//   makes never-written line entries read as zero, so no memory sweep is needed.
//   a delay write zeroes the fill counts the same way.
// stall:
//   while m_tready is low the result waits in the output register; the next item
//   is processed up to its output step and then holds until the register frees.
// ----------------------------------------------------------------------------
module feedback_delay_line_interp
    import fdl_pkg::*;
#(
    parameter int LINE_DEPTH  = 131072,
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample_in
    input  wire logic                                s_tuser,  // chan
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_tdata,  // sample_out
    output logic                                     m_tuser,  // chan_out
    input  wire logic                                cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]             cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]            cfg_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int DW   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AB   = SB + COEF_BITS + 1;
    localparam int AW   = $clog2(LINE_DEPTH);
    localparam int CNW  = $clog2(LINE_DEPTH + 1);
    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MAW  = $clog2(CHANNELS * LINE_DEPTH);
    localparam int RSH  = DELAY_BITS + AW;
    localparam int RPW  = 2 * DELAY_BITS + 1;

    localparam logic [AW:0]            DEPTH1 = (AW+1)'(LINE_DEPTH);
    localparam logic [AW-1:0]          LAST   = AW'(LINE_DEPTH - 1);
    localparam logic [CNW-1:0]         CFULL  = CNW'(LINE_DEPTH);
    localparam logic [DELAY_BITS:0]    RECIP  = (DELAY_BITS+1)'(
        ((64'd1 << RSH) + 64'(LINE_DEPTH) - 64'd1) / 64'(LINE_DEPTH));
    localparam logic signed [AB-1:0]   HALF16 = AB'(32768);
    localparam logic signed [AB-1:0]   HALF15 = AB'(16384);
    localparam logic signed [AB-1:0]   SMAX   = AB'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [AB-1:0]   SMIN   = AB'(-(64'sd1 <<< (SB - 1)));

    function automatic logic [SB-1:0] sat_fn(input logic signed [AB-1:0] v);
        logic [SB-1:0] r;
        if (v > SMAX)
        begin
            r = SMAX[SB-1:0];
        end
        else if (v < SMIN)
        begin
            r = SMIN[SB-1:0];
        end
        else
        begin
            r = v[SB-1:0];
        end
        return r;
    endfunction

    // configuration
    logic [DELAY_BITS-1:0] delay_whole_reg;
    logic [FRAC_BITS-1:0]  delay_fraction_reg;
    logic [GAIN_BITS-1:0]  feedback_gain_reg;
    logic [GAIN_BITS-1:0]  wet_gain_reg;

    // sequencer and channel state
    state_t                state_reg;
    state_t                state_next;
    logic [AW-1:0]         wp_reg  [CHANNELS];
    logic [CNW-1:0]        cnt_reg [CHANNELS];
    logic                  dist_ok_reg;
    logic [AW-1:0]         b0_reg;
    logic [DELAY_BITS-1:0] quo_reg;
    logic [RED_CNT_BITS-1:0] red_cnt_reg;

    // item payload
    logic [CW-1:0]         ch_reg;
    logic                  chan_reg;
    logic signed [SB-1:0]  x_reg;
    logic signed [SB-1:0]  delayed_reg;
    logic [SB-1:0]         out_sample_reg;
    logic                  out_chan_reg;
    logic                  m_tvalid_reg;

    // datapath signals
    logic                  accept;
    logic                  out_load;
    logic [CW-1:0]         ch_in;
    logic [AW-1:0]         wp_cur;
    logic [CNW-1:0]        cnt_cur;
    logic [AW-1:0]         b1;
    logic [AW:0]           t0;
    logic [AW:0]           t1;
    logic [AW-1:0]         idx0;
    logic [AW-1:0]         idx1;
    logic                  valid0;
    logic                  valid1;
    logic [RPW-1:0]        red_prod;
    logic [DELAY_BITS-1:0] quo_next;
    logic [DELAY_BITS-1:0] red_rem;
    logic [MAW-1:0]        line_base;
    logic [MAW-1:0]        ram_addr;
    logic                  ram_we;
    logic [SB-1:0]         ram_rdata;
    logic [SB-1:0]         pushed;
    logic [GAIN_BITS:0]    fb_c;
    logic [GAIN_BITS:0]    wet_c;
    mac_ctrl_t             mac_ctrl;
    logic signed [SB-1:0]  mac_a;
    logic signed [COEF_BITS-1:0] mac_b;
    logic signed [AB-1:0]  acc;
    logic signed [AB-1:0]  sum16;
    logic signed [AB-1:0]  sum15;
    logic signed [AB-1:0]  rnd16;
    logic signed [AB-1:0]  rnd15;
    logic signed [AB-1:0]  push_wide;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign ch_in    = (CHANNELS == 1) ? '0 : CW'(s_tuser);

    assign wp_cur  = wp_reg[ch_reg];
    assign cnt_cur = cnt_reg[ch_reg];

    // tap positions behind the newest stored sample
    assign b1   = (b0_reg == LAST) ? '0 : b0_reg + 1'b1;
    assign t0   = {1'b0, wp_cur} - {1'b0, b0_reg} - (AW+1)'(1);
    assign t1   = {1'b0, wp_cur} - {1'b0, b1} - (AW+1)'(1);
    assign idx0 = t0[AW] ? AW'(t0 + DEPTH1) : t0[AW-1:0];
    assign idx1 = t1[AW] ? AW'(t1 + DEPTH1) : t1[AW-1:0];

    // entries older than the fill count were never written since the last clear
    assign valid0 = CNW'(b0_reg) < cnt_cur;
    assign valid1 = CNW'(b1) < cnt_cur;

    // delay modulo line depth: reciprocal quotient, then remainder
    assign red_prod = RPW'(delay_whole_reg) * RPW'(RECIP);
    assign quo_next = DELAY_BITS'(red_prod >> RSH);
    assign red_rem  = delay_whole_reg - DELAY_BITS'(RPW'(quo_reg) * RPW'(LINE_DEPTH));

    assign fb_c  = ({1'b0, feedback_gain_reg} > GAIN_ONE || feedback_gain_reg[GAIN_BITS-1])
                   ? GAIN_ONE : {1'b0, feedback_gain_reg};
    assign wet_c = ({1'b0, wet_gain_reg} > GAIN_ONE || wet_gain_reg[GAIN_BITS-1])
                   ? GAIN_ONE : {1'b0, wet_gain_reg};

    assign sum16     = acc + HALF16;
    assign sum15     = acc + HALF15;
    assign rnd16     = sum16 >>> 16;
    assign rnd15     = sum15 >>> 15;
    assign push_wide = rnd15 + AB'(x_reg);
    assign pushed    = sat_fn(push_wide);

    assign line_base = MAW'(ch_reg) * MAW'(LINE_DEPTH);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mac_ctrl   = '0;
        mac_a      = '0;
        mac_b      = '0;
        ram_we     = 1'b0;
        ram_addr   = line_base + MAW'(idx0);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dist_ok_reg ? ST_RD0 : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (red_cnt_reg == '0)
                begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                ram_addr   = line_base + MAW'(idx0);
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                ram_addr   = line_base + MAW'(idx1);
                mac_a      = valid0 ? $signed(ram_rdata) : '0;
                mac_b      = $signed({1'b0, FRAC_ONE - {1'b0, delay_fraction_reg}});
                state_next = ST_BLEND0;
            end
            ST_BLEND0:
            begin
                mac_a         = valid1 ? $signed(ram_rdata) : '0;
                mac_b         = $signed({2'b00, delay_fraction_reg});
                mac_ctrl.load = 1'b1;
                state_next    = ST_BLEND1;
            end
            ST_BLEND1:
            begin
                mac_ctrl.accum = 1'b1;
                state_next     = ST_DLY;
            end
            ST_DLY:
            begin
                state_next = ST_FB;
            end
            ST_FB:
            begin
                mac_a      = delayed_reg;
                mac_b      = $signed({1'b0, fb_c});
                state_next = ST_WET;
            end
            ST_WET:
            begin
                mac_a         = delayed_reg;
                mac_b         = $signed({1'b0, wet_c});
                mac_ctrl.load = 1'b1;
                state_next    = ST_DRY;
            end
            ST_DRY:
            begin
                mac_a         = x_reg;
                mac_b         = $signed({1'b0, GAIN_ONE - wet_c});
                mac_ctrl.load = 1'b1;
                ram_we        = 1'b1;
                ram_addr      = line_base + MAW'(wp_cur);
                state_next    = ST_SUM;
            end
            ST_SUM:
            begin
                mac_ctrl.accum = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control state: config, positions, fill counts, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_whole_reg    <= '0;
            delay_fraction_reg <= '0;
            feedback_gain_reg  <= '0;
            wet_gain_reg       <= '0;
            dist_ok_reg        <= 1'b0;
            red_cnt_reg        <= '0;
            m_tvalid_reg       <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                red_cnt_reg <= RED_CNT_BITS'(1);
            end
            else if (state_reg == ST_REDUCE)
            begin
                red_cnt_reg <= red_cnt_reg - 1'b1;
                if (red_cnt_reg == '0)
                begin
                    dist_ok_reg <= 1'b1;
                end
            end

            if (state_reg == ST_DRY)
            begin
                wp_reg[ch_reg] <= (wp_cur == LAST) ? '0 : wp_cur + 1'b1;
                if (cnt_cur != CFULL)
                begin
                    cnt_reg[ch_reg] <= cnt_cur + 1'b1;
                end
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_DELAY_WHOLE:
                    begin
                        delay_whole_reg <= cfg_data;
                        dist_ok_reg     <= 1'b0;
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            cnt_reg[i] <= '0;
                        end
                    end
                    REG_DELAY_FRACTION:
                    begin
                        delay_fraction_reg <= cfg_data[FRAC_BITS-1:0];
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            cnt_reg[i] <= '0;
                        end
                    end
                    REG_FEEDBACK_GAIN:
                    begin
                        feedback_gain_reg <= cfg_data[GAIN_BITS-1:0];
                    end
                    REG_WET_GAIN:
                    begin
                        wet_gain_reg <= cfg_data[GAIN_BITS-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= ch_in;
            chan_reg <= s_tuser;
            x_reg    <= $signed(s_tdata[SB-1:0]);
        end
        if (state_reg == ST_REDUCE)
        begin
            if (red_cnt_reg != '0)
            begin
                quo_reg <= quo_next;
            end
            else
            begin
                b0_reg <= AW'(red_rem);
            end
        end
        if (state_reg == ST_DLY)
        begin
            delayed_reg <= rnd16[SB-1:0];
        end
        if (out_load)
        begin
            out_sample_reg <= sat_fn(rnd15);
            out_chan_reg   <= chan_reg;
        end
    end

    fdl_mac #(
        .A_BITS (SB)
    ) u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    fdl_ram #(
        .DEPTH (CHANNELS * LINE_DEPTH),
        .WIDTH (SB)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pushed),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DW'(out_sample_reg);
    assign m_tuser  = out_chan_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after an accepted word");

    a_reduced_before_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD0) |-> dist_ok_reg)
        else $error("tap read with unreduced delay");

    a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dist_ok_reg |-> ({1'b0, b0_reg} < DEPTH1))
        else $error("reduced delay outside the line");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CFULL)
        else $error("fill count beyond line depth");
`endif

endmodule
`default_nettype wire

[tb/feedback_delay_line_interp_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// feedback_delay_line_interp_tb
// self-checking bench for the interpolating two-channel feedback delay
//
// samples go in on the s_* stream and mixed samples come back on m_*. every
// accepted word is run through a local model of both delay lines, the tap
// blend, the feedback push and the dry/wet mix, and each returned word is
// compared field by field with the oldest prediction. directed tests cover
// pass-through, sample extremes, interpolation with full feedback, gains
// above one, taps past the line depth and clearing on a delay write. random
// phases then vary the settings and the idle patterns on both sides
// ----------------------------------------------------------------------------
module feedback_delay_line_interp_tb;
    import fdl_pkg::*;

    localparam int LINE_DEPTH  = 131072;
    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 24;
    localparam int WORD_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam int unsigned UNITY_GAIN = GAIN_ONE;
    localparam int unsigned UNITY_FRAC = FRAC_ONE;

    localparam int SETTLE_CYCLES   = 16;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 210;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   chan;
    } mix_word_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [WORD_BITS-1:0]     s_tdata   = '0;   // sample_in
    logic                     s_tuser   = 1'b0; // chan
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [WORD_BITS-1:0]     m_tdata;          // sample_out
    logic                     m_tuser;          // chan_out
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // local copy of registers and line state
    int unsigned delay_whole_q;
    int unsigned delay_fraction_q;
    int unsigned feedback_gain_q;
    int unsigned wet_gain_q;
    int unsigned write_pos [CHANNELS];
    longint      line_mem [int unsigned];

    mix_word_t   expected_mix [$];
    int unsigned error_count;
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned settings_used;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    feedback_delay_line_interp #(
        .LINE_DEPTH  (LINE_DEPTH),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("timeout at %0t with %0d words outstanding", $time, expected_mix.size());
        $display("feedback_delay_line_interp_tb failed");
        $finish;
    end

    // round half up: add half, then floor
    function automatic longint round_q(input longint v, input int unsigned shift);
        return (v + (longint'(1) <<< (shift - 1))) >>> shift;
    endfunction

    function automatic longint clip_sample(input longint v);
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            return SAMPLE_MIN;
        return v;
    endfunction

    function automatic int unsigned clamp_gain(input int unsigned g);
        return (g > UNITY_GAIN) ? UNITY_GAIN : g;
    endfunction

    function automatic longint tap_read(input int unsigned line, input int unsigned back);
        int unsigned slot;
        slot = (write_pos[line] + 2 * LINE_DEPTH - 1 - (back % LINE_DEPTH)) % LINE_DEPTH;
        slot = line * LINE_DEPTH + slot;
        return line_mem.exists(slot) ? line_mem[slot] : 0;
    endfunction

    function automatic int unsigned pick_gain();
        case ($urandom_range(7))
            0:       return 0;
            1:       return UNITY_GAIN;
            2:       return $urandom_range(65535, UNITY_GAIN + 1);
            default: return $urandom_range(UNITY_GAIN);
        endcase
    endfunction

    // blend the two taps, push the feedback sum and mix dry with wet
    function automatic mix_word_t mix_sample(input logic ch, input logic [SAMPLE_BITS-1:0] raw);
        int unsigned line;
        int unsigned frac;
        int unsigned fb;
        int unsigned wet;
        longint      x;
        longint      y0;
        longint      y1;
        longint      delayed;
        longint      mixed;
        mix_word_t   res;
        line    = int'(ch) % CHANNELS;
        frac    = delay_fraction_q;
        fb      = clamp_gain(feedback_gain_q);
        wet     = clamp_gain(wet_gain_q);
        x       = longint'($signed(raw));
        y0      = tap_read(line, delay_whole_q);
        y1      = tap_read(line, delay_whole_q + 1);
        delayed = round_q(y0 * longint'(UNITY_FRAC - frac) + y1 * longint'(frac), 16);
        line_mem[line * LINE_DEPTH + write_pos[line]] =
            clip_sample(x + round_q(delayed * longint'(fb), 15));
        write_pos[line] = (write_pos[line] + 1) % LINE_DEPTH;
        mixed = clip_sample(round_q(x * longint'(UNITY_GAIN - wet) + delayed * longint'(wet), 15));
        res.sample = mixed[SAMPLE_BITS-1:0];
        res.chan   = ch;
        return res;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DELAY_WHOLE:
            begin
                delay_whole_q = value & 32'h1FFFF;
                line_mem.delete();
            end
            REG_DELAY_FRACTION:
            begin
                delay_fraction_q = value & 32'hFFFF;
                line_mem.delete();
            end
            REG_FEEDBACK_GAIN:
                feedback_gain_q = value & 32'hFFFF;
            REG_WET_GAIN:
                wet_gain_q = value & 32'hFFFF;
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic apply_setting(input int unsigned whole, input int unsigned frac,
                                 input int unsigned fb, input int unsigned wet);
        write_reg(REG_DELAY_WHOLE, whole);
        write_reg(REG_DELAY_FRACTION, frac);
        write_reg(REG_FEEDBACK_GAIN, fb);
        write_reg(REG_WET_GAIN, wet);
        settings_used++;
    endtask

    task automatic send_word(input logic ch, input logic [SAMPLE_BITS-1:0] sample);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= WORD_BITS'(sample);
        s_tuser  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_mix.push_back(mix_sample(ch, sample));
        words_sent++;
    endtask

    // let every prediction drain, then give the block time to go idle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_mix.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        mix_word_t exp_word;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_checked++;
            if (expected_mix.size() == 0)
            begin
                $display("%0t unexpected word: expected none, got sample %h chan %b",
                         $time, m_tdata[SAMPLE_BITS-1:0], m_tuser);
                error_count++;
            end
            else
            begin
                exp_word = expected_mix.pop_front();
                if (m_tdata[SAMPLE_BITS-1:0] !== exp_word.sample)
                begin
                    $display("%0t sample_out mismatch: expected %h, got %h",
                             $time, exp_word.sample, m_tdata[SAMPLE_BITS-1:0]);
                    error_count++;
                end
                if (m_tuser !== exp_word.chan)
                begin
                    $display("%0t chan_out mismatch: expected %b, got %b",
                             $time, exp_word.chan, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // reset registers: zero delay and zero wet gain pass the input straight through
    task automatic test_passthrough();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(1'b0, 24'h7FFFFF);
        send_word(1'b1, 24'h800000);
        send_word(1'b0, 24'h000000);
        send_word(1'b1, 24'hFFFFFF);
        send_word(1'b0, 24'h000001);
        send_word(1'b1, 24'h555555);
        wait_idle();
    endtask

    // half-sample tap with unity feedback drives the lines into saturation
    task automatic test_interp_feedback();
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        apply_setting(2, 32'h8000, UNITY_GAIN, 16384);
        repeat (4)
        begin
            send_word(1'b0, 24'h7FFFFF);
            send_word(1'b1, 24'h800000);
        end
        wait_idle();
    endtask

    // gain codes above one act as one
    task automatic test_gain_above_one();
        apply_setting(1, 0, 65535, 65535);
        send_word(1'b0, 24'h400000);
        send_word(1'b0, 24'h123456);
        send_word(1'b1, 24'hC00000);
        send_word(1'b1, 24'h000100);
        wait_idle();
    endtask

    // whole delay at the top of its range wraps the far tap onto the newest slot
    task automatic test_long_delay();
        apply_setting(131071, 65535, 16384, UNITY_GAIN);
        send_word(1'b0, 24'h3ABCDE);
        send_word(1'b0, 24'hA00001);
        send_word(1'b0, 24'h7FFFFF);
        wait_idle();
    endtask

    // a fraction write empties the lines but write positions carry on
    task automatic test_clear_keeps_position();
        apply_setting(1, 0, 0, UNITY_GAIN);
        send_word(1'b1, 24'h2468AC);
        send_word(1'b1, 24'h13579B);
        wait_idle();
        write_reg(REG_DELAY_FRACTION, 0);
        send_word(1'b1, 24'h7A5A5A);
        wait_idle();
    endtask

    task automatic test_random_mixing();
        int unsigned            phase;
        int unsigned            whole;
        int unsigned            frac;
        logic [SAMPLE_BITS-1:0] sample;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(7))
                0:       whole = 0;
                1:       whole = $urandom_range(131071, 100);
                default: whole = $urandom_range(48, 1);
            endcase
            case ($urandom_range(5))
                0:       frac = 0;
                1:       frac = 65535;
                default: frac = $urandom_range(65535);
            endcase
            if (phase == 0)
                apply_setting(0, 0, UNITY_GAIN, UNITY_GAIN);
            else if (phase == 1)
                apply_setting(131071, 65535, 65535, 0);
            else
                apply_setting(whole, frac, pick_gain(), pick_gain());
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 88;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            repeat (WORDS_PER_PHASE)
            begin
                case ($urandom_range(9))
                    0:       sample = 24'h800000;
                    1:       sample = 24'h7FFFFF;
                    2, 3, 4: sample = SAMPLE_BITS'($urandom_range(4095)) - 24'd2048;
                    default: sample = SAMPLE_BITS'($urandom);
                endcase
                send_word(1'($urandom_range(1)), sample);
            end
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_interp_feedback();
        test_gain_above_one();
        test_long_delay();
        test_clear_keeps_position();
        test_random_mixing();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_mix.size() != 0)
            $display("%0d predicted words never returned", expected_mix.size());
        $display("sent %0d sample words under %0d register settings, %0d words checked",
                 words_sent, settings_used, words_checked);
        $display("idle patterns: none, sender only, receiver only, both sides");
        if (error_count == 0 && expected_mix.size() == 0)
            $display("feedback_delay_line_interp_tb passed");
        else
            $display("feedback_delay_line_interp_tb failed");
        $finish;
    end

endmodule

[feedback_delay_line_interp.f]
rtl/fdl_pkg.sv
rtl/fdl_mac.sv
rtl/fdl_ram.sv
rtl/feedback_delay_line_interp.sv
tb/feedback_delay_line_interp_tb.sv
